// File: rtl/core/bgu_pkg.sv
// Shared types and constants of the genotype byte unpacker.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package bgu_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_INDEX_W = 1;
   localparam int CELL_W      = 40;
   localparam int GENO_W      = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] MAGIC_FIRST  = 8'h6C;
   localparam logic [BYTE_W-1:0] MAGIC_SECOND = 8'h1B;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COL_COUNT = 1'd1;

   typedef enum logic [2:0] {
      ST_MAGIC0,
      ST_MAGIC1,
      ST_ORDER,
      ST_DATA,
      ST_ERROR
   } hdr_state_type;

   typedef enum logic {
      ENTRY_DATA,
      ENTRY_ERROR
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type    kind;
      logic              by_locus;
      logic [BYTE_W-1:0] byte_value;
   } entry_type;

   // Fixed recoding of a raw 2-bit pair.
   function automatic logic [GENO_W-1:0] geno_recode(input logic [GENO_W-1:0] code);
      logic [GENO_W-1:0] g;
      case (code)
         2'd0: g = 2'd1;
         2'd1: g = 2'd0;
         2'd2: g = 2'd2;
         2'd3: g = 2'd3;
         default: g = 2'd0;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/bgu_front.sv
// Header parser of the genotype byte unpacker: magic check and order byte.
// Depends on bgu_pkg; feeds data and error words to bgu_queue.
`default_nettype none

module bgu_front
   import bgu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_byte_value,
   input  wire logic              q_full,
   output logic                   q_push,
   output entry_type              q_entry
);

   hdr_state_type state_ff, state_in;
   logic          by_locus_ff, by_locus_in;
   logic          accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      by_locus_in = by_locus_ff;
      if (accept) begin
         case (state_ff)
            ST_MAGIC0: begin
               state_in = (req_byte_value == MAGIC_FIRST) ? ST_MAGIC1 : ST_ERROR;
            end
            ST_MAGIC1: begin
               state_in = (req_byte_value == MAGIC_SECOND) ? ST_ORDER : ST_ERROR;
            end
            ST_ORDER: begin
               state_in    = ST_DATA;
               by_locus_in = (req_byte_value != '0);
            end
            ST_DATA:  state_in = ST_DATA;
            ST_ERROR: state_in = ST_ERROR;
            default:  state_in = ST_ERROR;
         endcase
      end
   end

   always_comb begin
      q_push                = 1'b0;
      q_entry.kind          = ENTRY_DATA;
      q_entry.by_locus      = by_locus_ff;
      q_entry.byte_value    = req_byte_value;
      case (state_ff)
         ST_MAGIC0: begin
            q_push       = accept && (req_byte_value != MAGIC_FIRST);
            q_entry.kind = ENTRY_ERROR;
         end
         ST_MAGIC1: begin
            q_push       = accept && (req_byte_value != MAGIC_SECOND);
            q_entry.kind = ENTRY_ERROR;
         end
         ST_DATA: begin
            q_push = accept;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_MAGIC0;
         by_locus_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         by_locus_ff <= by_locus_in;
      end
   end

   // Once the magic number fails, the parser stays silent for good.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ERROR |=> state_ff == ST_ERROR)
      else $error("front left the error state");

   a_error_no_push: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ERROR || state_ff == ST_ORDER |-> !q_push)
      else $error("front pushed a word after an error or on the order byte");

endmodule

`default_nettype wire

// File: rtl/core/bgu_queue.sv
// Short word queue between the header parser and the pair sequencer.
// Depends on bgu_pkg for the queued word type and its depth.
`default_nettype none

module bgu_queue
   import bgu_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output entry_type      head_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above its depth");

endmodule

`default_nettype wire

// File: rtl/core/bgu_back.sv
// Pair sequencer of the genotype byte unpacker: one genotype per cycle unless
// stalled, matrix cell tracking, registered result word. Depends on bgu_pkg.
`default_nettype none

module bgu_back
   import bgu_pkg::*;
#(
   parameter int ROW_W = 21,
   parameter int COL_W = 21
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [ROW_W-1:0]  row_count,
   input  wire logic [COL_W-1:0]  col_count,
   input  wire logic              q_valid,
   input  wire entry_type         q_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CELL_W-1:0]      rsp_cell_index,
   output logic [GENO_W-1:0]      rsp_genotype,
   output logic                   rsp_status,
   output logic                   rsp_last_of_byte,
   output logic                   rsp_matrix_done
);

   logic [1:0]        pair_ff, pair_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              fin_ff, fin_in;
   logic              valid_ff;

   logic              out_free, load;
   logic [ROW_W:0]    row_inc;
   logic [COL_W:0]    col_inc;
   logic [GENO_W-1:0] code;
   logic              wrap, done, end_byte;
   logic [CELL_W-1:0] res_cell;
   logic [GENO_W-1:0] res_geno;
   logic              res_status, res_last, res_done;

   assign out_free = !valid_ff || !rsp_stall;
   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign code     = q_entry.byte_value[{pair_ff, 1'b0} +: GENO_W];

   always_comb begin
      pair_in    = pair_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      cell_in    = cell_ff;
      fin_in     = fin_ff;
      q_pop      = 1'b0;
      load       = 1'b0;
      wrap       = 1'b0;
      done       = 1'b0;
      end_byte   = 1'b0;
      res_cell   = cell_ff;
      res_geno   = geno_recode(code);
      res_status = 1'b0;
      res_last   = 1'b0;
      res_done   = 1'b0;
      if (q_valid) begin
         if (q_entry.kind == ENTRY_ERROR) begin
            if (out_free) begin
               load       = 1'b1;
               q_pop      = 1'b1;
               res_cell   = '0;
               res_geno   = '0;
               res_status = 1'b1;
               res_last   = 1'b1;
            end
         end else if (fin_ff) begin
            // The matrix is full: later words are dropped unseen.
            q_pop = 1'b1;
         end else if (out_free) begin
            load = 1'b1;
            if (q_entry.by_locus) begin
               cell_in = cell_ff + 1'b1;
               if (row_inc >= {1'b0, row_count}) begin
                  wrap   = 1'b1;
                  row_in = '0;
                  col_in = col_inc[COL_W-1:0];
                  done   = (col_inc >= {1'b0, col_count});
               end else begin
                  row_in = row_inc[ROW_W-1:0];
               end
            end else begin
               cell_in = cell_ff + CELL_W'(row_count);
               if (col_inc >= {1'b0, col_count}) begin
                  wrap    = 1'b1;
                  col_in  = '0;
                  row_in  = row_inc[ROW_W-1:0];
                  done    = (row_inc >= {1'b0, row_count});
                  cell_in = CELL_W'(row_inc);
               end else begin
                  col_in = col_inc[COL_W-1:0];
               end
            end
            end_byte = (pair_ff == 2'd3) || wrap || done;
            res_last = end_byte;
            res_done = done;
            if (done) begin
               fin_in = 1'b1;
            end
            if (end_byte) begin
               q_pop   = 1'b1;
               pair_in = '0;
            end else begin
               pair_in = pair_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         cell_ff  <= '0;
         fin_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pair_ff <= pair_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         cell_ff <= cell_in;
         fin_ff  <= fin_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_cell_index   <= res_cell;
         rsp_genotype     <= res_geno;
         rsp_status       <= res_status;
         rsp_last_of_byte <= res_last;
         rsp_matrix_done  <= res_done;
      end
   end

   assign rsp_valid = valid_ff;

   // A byte is only ever partly unpacked while it is still at the queue head.
   a_pair_needs_word: assert property (@(posedge clock) disable iff (reset)
      pair_ff != 2'd0 |-> q_valid && q_entry.kind == ENTRY_DATA)
      else $error("pair index advanced without a data word");

   a_done_sets_finished: assert property (@(posedge clock) disable iff (reset)
      load && res_done |=> fin_ff)
      else $error("final cell did not set the finished flag");

   a_no_genotype_after_done: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !(load && !res_status))
      else $error("genotype emitted after the matrix was complete");

endmodule

`default_nettype wire

// File: rtl/core/bed_genotype_unpacker_unit.sv
// Genotype byte unpacker: takes packed 2-bit genotype file bytes, one word
// per req_ handshake, and gives recoded genotypes with their column-major
// cell index, one word per rsp_ handshake. Depends on bgu_pkg and on
// bgu_front, bgu_queue and bgu_back.
//
// The first two bytes are the magic number; a mismatch gives one error word
// (status set) and every later byte is taken and ignored. The third byte sets
// SNP-major (nonzero) or individual-major order. Each data byte then yields
// up to four genotype words, low pair first; the pair sequencer makes one per
// cycle while rsp_ is not stalled. The first word of a byte passes through a
// queue slot and then the registered result word. After the word that fills
// the final cell, later bytes are taken and dropped.
// Row and column counts are written through the csr_ port; the user must
// write them only while the block is idle, and the block itself does not
// enforce this. Both reset to 1. A stalled rsp_ word holds; two queued bytes
// decouple the input, so req_stall rises once the queue is full. Synchronous
// reset returns to the start of the header with an empty queue and no result.
`default_nettype none

module bed_genotype_unpacker_unit
   import bgu_pkg::*;
#(
   parameter int MAX_ROWS = 1048576,
   parameter int MAX_COLS = 1048576
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [BYTE_W-1:0]      req_byte_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [CELL_W-1:0]           rsp_cell_index,
   output logic [GENO_W-1:0]           rsp_genotype,
   output logic                        rsp_status,
   output logic                        rsp_last_of_byte,
   output logic                        rsp_matrix_done
);

   localparam int ROW_W = $clog2(MAX_ROWS + 1);
   localparam int COL_W = $clog2(MAX_COLS + 1);

   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [COL_W-1:0] col_count_ff, col_count_in;

   logic      q_full, q_push, q_pop, q_valid;
   entry_type push_entry, head_entry;

   // Counts are stored already clamped to one and to their maximum.
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               if (csr_wdata == '0) begin
                  row_count_in = ROW_W'(1);
               end else if (32'(csr_wdata) > 32'(MAX_ROWS)) begin
                  row_count_in = ROW_W'(MAX_ROWS);
               end else begin
                  row_count_in = ROW_W'(csr_wdata);
               end
            end
            CSR_COL_COUNT: begin
               if (csr_wdata == '0) begin
                  col_count_in = COL_W'(1);
               end else if (32'(csr_wdata) > 32'(MAX_COLS)) begin
                  col_count_in = COL_W'(MAX_COLS);
               end else begin
                  col_count_in = COL_W'(csr_wdata);
               end
            end
            default: begin
               row_count_in = row_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_W'(1);
         col_count_ff <= COL_W'(1);
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   bgu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   bgu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   bgu_back #(
      .ROW_W (ROW_W),
      .COL_W (COL_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .row_count        (row_count_ff),
      .col_count        (col_count_ff),
      .q_valid          (q_valid),
      .q_entry          (head_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_index   (rsp_cell_index),
      .rsp_genotype     (rsp_genotype),
      .rsp_status       (rsp_status),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_matrix_done  (rsp_matrix_done)
   );

endmodule

`default_nettype wire
